// ===== rtl/tvb_pkg.sv =====
package tvb_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEIGHT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_X         = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_Z         = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_HEIGHT    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_WIDTH = 4'd7;

    // fraction bits of a Q0.16 ratio and width of a ratio that may reach one
    localparam int FRAC_BITS = 16;
    localparam int QW        = FRAC_BITS + 1;
    localparam logic [QW-1:0] ONE_Q16 = 17'h1_0000;

    // square root unit geometry
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int SQRT_REM_W  = ROOT_W + 2;

    // squared minimum segment length (0.01) for each prescale shift
    localparam logic [63:0] SEG_MIN_SQ0 = 64'd429025;
    localparam logic [63:0] SEG_MIN_SQ1 = 64'd107584;
    localparam logic [63:0] SEG_MIN_SQ2 = 64'd26896;

    // prescale limits on the largest difference magnitude
    localparam logic [63:0] SHIFT_LIM0 = 64'h0000_0000_4000_0000;
    localparam logic [63:0] SHIFT_LIM1 = 64'h0000_0000_8000_0000;

    // 3.0 in Q16 for the smoothstep polynomial
    localparam logic [17:0] SMOOTH_K = 18'd196608;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_z;
        logic signed [31:0] current_height;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] new_height;
        logic               touched;
    } result_t;

    // quotient overrides applied at the divider output
    typedef struct packed {
        logic sat;
        logic zero;
    } div_flag_t;

endpackage

// ===== rtl/tvb_div.sv =====
module tvb_div #(
    parameter int  W      = 62,
    parameter type side_t = logic
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [W-1:0]           num,
    input  logic [W-1:0]           den,
    input  tvb_pkg::div_flag_t     flag,
    input  side_t                  side_in,
    output logic                   out_vld,
    output logic [tvb_pkg::QW-1:0] quo,
    output side_t                  side_out
);
    import tvb_pkg::*;

    localparam int STAGES = FRAC_BITS;

    logic                 vld_reg  [STAGES];
    logic [W-1:0]         rem_reg  [STAGES];
    logic [W-1:0]         den_reg  [STAGES];
    logic [FRAC_BITS-1:0] q_reg    [STAGES];
    div_flag_t            flag_reg [STAGES];
    side_t                side_reg [STAGES];

    // one quotient bit per stage, restoring; requires num < den
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic                 vld_in;
        logic [W-1:0]         rem_in;
        logic [W-1:0]         den_in;
        logic [FRAC_BITS-1:0] q_in;
        div_flag_t            flag_in;
        side_t                side_s;
        logic [W:0]           shl;
        logic [W:0]           diff;
        logic                 ge;

        if (i == 0) begin : g_head
            assign vld_in  = in_vld;
            assign rem_in  = num;
            assign den_in  = den;
            assign q_in    = '0;
            assign flag_in = flag;
            assign side_s  = side_in;
        end
        else begin : g_tail
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign flag_in = flag_reg[i-1];
            assign side_s  = side_reg[i-1];
        end

        assign shl  = {rem_in, 1'b0};
        assign ge   = shl >= {1'b0, den_in};
        assign diff = shl - {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[W-1:0] : shl[W-1:0];
                q_reg[i]    <= {q_in[FRAC_BITS-2:0], ge};
                den_reg[i]  <= den_in;
                flag_reg[i] <= flag_in;
                side_reg[i] <= side_s;
            end
        end
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];
    assign quo      = flag_reg[STAGES-1].sat  ? ONE_Q16 :
                      flag_reg[STAGES-1].zero ? '0      : {1'b0, q_reg[STAGES-1]};

endmodule

// ===== rtl/tvb_sqrt.sv =====
module tvb_sqrt #(
    parameter type side_t = logic
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [tvb_pkg::RAD_W-1:0]  rad,
    input  side_t                      side_in,
    output logic                       out_vld,
    output logic [tvb_pkg::ROOT_W-1:0] root,
    output side_t                      side_out
);
    import tvb_pkg::*;

    localparam int STAGES = ROOT_W;

    logic                  vld_reg  [STAGES];
    logic [RAD_W-1:0]      rad_reg  [STAGES];
    logic [SQRT_REM_W-1:0] rem_reg  [STAGES];
    logic [ROOT_W-1:0]     root_reg [STAGES];
    side_t                 side_reg [STAGES];

    // one root bit per stage from the next two radicand bits
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic                  vld_in;
        logic [RAD_W-1:0]      rad_in;
        logic [SQRT_REM_W-1:0] rem_in;
        logic [ROOT_W-1:0]     root_in;
        side_t                 side_s;
        logic [SQRT_REM_W+1:0] cat;
        logic [SQRT_REM_W+1:0] trial;
        logic [SQRT_REM_W+1:0] diff;
        logic                  ge;

        if (i == 0) begin : g_head
            assign vld_in  = in_vld;
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_s  = side_in;
        end
        else begin : g_tail
            assign vld_in  = vld_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_s  = side_reg[i-1];
        end

        assign cat   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = cat >= trial;
        assign diff  = cat - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i]  <= {rad_in[RAD_W-3:0], 2'b00};
                rem_reg[i]  <= ge ? diff[SQRT_REM_W-1:0] : cat[SQRT_REM_W-1:0];
                root_reg[i] <= {root_in[ROOT_W-2:0], ge};
                side_reg[i] <= side_s;
            end
        end
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign root     = root_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];

endmodule

// ===== rtl/terrain_ramp_vertex_blend.sv =====
// throughput: one vertex per cycle whenever the pipeline is not held;
// fully pipelined (two 16-stage dividers, 32-stage sqrt)
// the whole pipeline holds while a result waits unaccepted; ready follows that hold
// reset (rst_n low, async) clears all valid bits and sets every config register to zero
// config writes are taken every cycle and apply to vertices in flight
module terrain_ramp_vertex_blend #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            vertex_valid,
    output logic                            vertex_ready,
    input  tvb_pkg::vertex_t                vertex,
    output logic                            result_valid,
    input  logic                            result_ready,
    output tvb_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tvb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import tvb_pkg::*;

    localparam int EW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int DW = EW + 1;
    localparam int TW = 62;
    localparam int FW = 31;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] az;
        logic signed [31:0] dx;
        logic signed [31:0] dz;
        logic [1:0]         scl;
        logic               seg_ok;
        logic signed [31:0] cur;
    } tside_t;

    typedef struct packed {
        logic [1:0]         scl;
        logic               seg_ok;
        logic signed [31:0] cur;
        logic signed [33:0] target;
    } sside_t;

    typedef struct packed {
        logic               in_fp;
        logic               band;
        logic signed [31:0] cur;
        logic signed [33:0] target;
    } fside_t;

    function automatic logic signed [DW-1:0] sx(input logic [31:0] v);
        return DW'(signed'(v[EW-1:0]));
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic signed [31:0] scale(input logic signed [DW-1:0] v,
                                                 input logic [1:0] s);
        logic signed [33:0] w;
        w = 34'(v);
        w = w >>> s;
        return signed'(w[31:0]);
    endfunction

    // configuration registers
    logic signed [31:0] start_x_reg, start_z_reg, start_h_reg;
    logic signed [31:0] end_x_reg, end_z_reg, end_h_reg;
    logic [30:0]        half_w_reg, fall_w_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_z_reg <= '0;
            start_h_reg <= '0;
            end_x_reg   <= '0;
            end_z_reg   <= '0;
            end_h_reg   <= '0;
            half_w_reg  <= '0;
            fall_w_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_X:       start_x_reg <= cfg_data;
                REG_START_Z:       start_z_reg <= cfg_data;
                REG_START_HEIGHT:  start_h_reg <= cfg_data;
                REG_END_X:         end_x_reg   <= cfg_data;
                REG_END_Z:         end_z_reg   <= cfg_data;
                REG_END_HEIGHT:    end_h_reg   <= cfg_data;
                REG_HALF_WIDTH:    half_w_reg  <= cfg_data[30:0];
                REG_FALLOFF_WIDTH: fall_w_reg  <= cfg_data[30:0];
                default:           ;
            endcase
        end
    end

    // global pipeline advance
    logic adv;
    assign adv          = !result_valid || result_ready;
    assign vertex_ready = adv;

    // stage A: differences from the ramp start
    logic                 a_vld_reg;
    logic signed [DW-1:0] ax_a_reg, az_a_reg, dx_a_reg, dz_a_reg;
    logic signed [DW-1:0] ax_a_next, az_a_next, dx_a_next, dz_a_next;
    logic signed [31:0]   cur_a_reg;

    always_comb
    begin
        ax_a_next = sx(vertex.vertex_x) - sx(start_x_reg);
        az_a_next = sx(vertex.vertex_z) - sx(start_z_reg);
        dx_a_next = sx(end_x_reg) - sx(start_x_reg);
        dz_a_next = sx(end_z_reg) - sx(start_z_reg);
    end

    // stage B: prescale so every magnitude stays within 2^30
    logic               b_vld_reg;
    logic [DW-1:0]      m_b;
    logic [1:0]         scl_b_next, scl_b_reg;
    logic signed [31:0] ax_b_reg, az_b_reg, dx_b_reg, dz_b_reg, cur_b_reg;

    always_comb
    begin
        m_b = mag(ax_a_reg);
        if (mag(az_a_reg) > m_b)
        begin
            m_b = mag(az_a_reg);
        end
        if (mag(dx_a_reg) > m_b)
        begin
            m_b = mag(dx_a_reg);
        end
        if (mag(dz_a_reg) > m_b)
        begin
            m_b = mag(dz_a_reg);
        end
        if (64'(m_b) <= SHIFT_LIM0)
        begin
            scl_b_next = 2'd0;
        end
        else if (64'(m_b) <= SHIFT_LIM1)
        begin
            scl_b_next = 2'd1;
        end
        else
        begin
            scl_b_next = 2'd2;
        end
    end

    // stage C: dot and length products
    logic               c_vld_reg;
    logic signed [63:0] axdx_c_reg, azdz_c_reg, dxx_c_reg, dzz_c_reg;
    logic signed [31:0] ax_c_reg, az_c_reg, dx_c_reg, dz_c_reg, cur_c_reg;
    logic [1:0]         scl_c_reg;

    // stage D: sums, short segment test and divider setup
    logic               d_vld_reg;
    logic signed [63:0] num_d_next;
    logic [63:0]        den_d_next;
    logic               seg_ok_d_next;
    div_flag_t          tflag_d_next, tflag_d_reg;
    logic [TW-1:0]      num_d_reg, den_d_reg;
    tside_t             tside_d_reg;

    always_comb
    begin
        num_d_next = axdx_c_reg + azdz_c_reg;
        den_d_next = $unsigned(dxx_c_reg + dzz_c_reg);
        case (scl_c_reg)
            2'd0:    seg_ok_d_next = den_d_next >= SEG_MIN_SQ0;
            2'd1:    seg_ok_d_next = den_d_next >= SEG_MIN_SQ1;
            default: seg_ok_d_next = den_d_next >= SEG_MIN_SQ2;
        endcase
        tflag_d_next.zero = num_d_next <= 64'sd0;
        tflag_d_next.sat  = !tflag_d_next.zero && (num_d_next >= signed'(den_d_next));
    end

    // projection ratio t
    logic           t_vld;
    logic [QW-1:0]  t_q;
    tside_t         t_side;

    tvb_div #(
        .W      (TW),
        .side_t (tside_t)
    ) u_div_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (d_vld_reg),
        .num      (num_d_reg),
        .den      (den_d_reg),
        .flag     (tflag_d_reg),
        .side_in  (tside_d_reg),
        .out_vld  (t_vld),
        .quo      (t_q),
        .side_out (t_side)
    );

    // stage E: scale direction and height delta by t
    logic               e_vld_reg;
    logic signed [32:0] dh_e;
    logic signed [49:0] dxt_e_next, dzt_e_next, dxt_e_reg, dzt_e_reg;
    logic signed [50:0] hdt_e_next, hdt_e_reg;
    logic signed [31:0] ax_e_reg, az_e_reg, cur_e_reg;
    logic [1:0]         scl_e_reg;
    logic               seg_ok_e_reg;

    always_comb
    begin
        dh_e       = 33'(end_h_reg) - 33'(start_h_reg);
        dxt_e_next = t_side.dx * signed'({1'b0, t_q});
        dzt_e_next = t_side.dz * signed'({1'b0, t_q});
        hdt_e_next = dh_e * signed'({1'b0, t_q});
    end

    // stage F: perpendicular components and ramp target height
    logic               f_vld_reg;
    logic signed [51:0] pxf_f, pzf_f, pxr_f, pzr_f;
    logic signed [50:0] hr_f;
    logic [31:0]        magx_f_next, magz_f_next, magx_f_reg, magz_f_reg;
    logic signed [33:0] target_f_next, target_f_reg;
    logic signed [31:0] cur_f_reg;
    logic [1:0]         scl_f_reg;
    logic               seg_ok_f_reg;

    always_comb
    begin
        pxf_f = (52'(ax_e_reg) <<< 16) - 52'(dxt_e_reg);
        pzf_f = (52'(az_e_reg) <<< 16) - 52'(dzt_e_reg);
        pxr_f = (pxf_f + 52'sd32768) >>> 16;
        pzr_f = (pzf_f + 52'sd32768) >>> 16;
        magx_f_next = pxr_f[51] ? 32'(-pxr_f) : pxr_f[31:0];
        magz_f_next = pzr_f[51] ? 32'(-pzr_f) : pzr_f[31:0];
        hr_f          = (hdt_e_reg + 51'sd32768) >>> 16;
        target_f_next = 34'(start_h_reg) + signed'(hr_f[33:0]);
    end

    // stage G: squares, stage H: radicand
    logic               g_vld_reg, h_vld_reg;
    logic [63:0]        sqx_g_reg, sqz_g_reg, rad_h_reg;
    sside_t             sside_g_reg, sside_h_reg;

    logic               s_vld;
    logic [ROOT_W-1:0]  s_root;
    sside_t             s_side;

    tvb_sqrt #(
        .side_t (sside_t)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (h_vld_reg),
        .rad      (rad_h_reg),
        .side_in  (sside_h_reg),
        .out_vld  (s_vld),
        .root     (s_root),
        .side_out (s_side)
    );

    // stage I: footprint test and falloff divider setup
    logic               i_vld_reg;
    logic [33:0]        perp_i, diff_i;
    logic [31:0]        lim_i;
    logic               in_fp_i, band_i;
    logic [FW-1:0]      fnum_i_reg;
    div_flag_t          fflag_i_next, fflag_i_reg;
    fside_t             fside_i_reg;

    always_comb
    begin
        perp_i  = 34'(s_root) << s_side.scl;
        lim_i   = 32'(half_w_reg) + 32'(fall_w_reg);
        in_fp_i = s_side.seg_ok && (perp_i <= 34'(lim_i));
        band_i  = in_fp_i && (perp_i > 34'(half_w_reg)) && (fall_w_reg != '0);
        diff_i  = perp_i - 34'(half_w_reg);
        fflag_i_next.zero = !band_i;
        fflag_i_next.sat  = band_i && (diff_i[FW-1:0] == fall_w_reg);
    end

    // falloff fraction f
    logic           fq_vld;
    logic [QW-1:0]  f_q;
    fside_t         f_side;

    tvb_div #(
        .W      (FW),
        .side_t (fside_t)
    ) u_div_f (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (i_vld_reg),
        .num      (fnum_i_reg),
        .den      (fall_w_reg),
        .flag     (fflag_i_reg),
        .side_in  (fside_i_reg),
        .out_vld  (fq_vld),
        .quo      (f_q),
        .side_out (f_side)
    );

    // stages J..M: smoothstep, blend weight and weighted delta
    logic               j_vld_reg, k_vld_reg, l_vld_reg, m_vld_reg;
    logic [33:0]        fsq_j_reg;
    logic [17:0]        kf_j_next, kf_j_reg;
    logic [51:0]        prod_k_reg;
    logic [51:0]        rsum_l;
    logic [QW-1:0]      blend_l_next, blend_l_reg;
    logic signed [34:0] delta_l_reg;
    logic signed [52:0] pr_m_reg;
    fside_t             side_j_reg, side_k_reg, side_l_reg, side_m_reg;

    assign kf_j_next = SMOOTH_K - {f_q, 1'b0};

    always_comb
    begin
        rsum_l = prod_k_reg + 52'h0_0000_8000_0000;
        if (side_k_reg.band)
        begin
            blend_l_next = QW'(20'(ONE_Q16) - rsum_l[51:32]);
        end
        else
        begin
            blend_l_next = ONE_Q16;
        end
    end

    // stage N: final round, add and saturate
    logic signed [52:0] adj_n;
    logic signed [37:0] sum_n;
    logic signed [31:0] newh_n;
    result_t            result_next, result_reg;
    logic               result_valid_reg;

    always_comb
    begin
        adj_n = (pr_m_reg + 53'sd32768) >>> 16;
        sum_n = 38'(side_m_reg.cur) + 38'(adj_n);
        if (sum_n > 38'(SAT_MAX))
        begin
            newh_n = SAT_MAX;
        end
        else if (sum_n < 38'(SAT_MIN))
        begin
            newh_n = SAT_MIN;
        end
        else
        begin
            newh_n = signed'(sum_n[31:0]);
        end
        result_next.new_height = side_m_reg.in_fp ? newh_n : side_m_reg.cur;
        result_next.touched    = side_m_reg.in_fp;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg        <= 1'b0;
            b_vld_reg        <= 1'b0;
            c_vld_reg        <= 1'b0;
            d_vld_reg        <= 1'b0;
            e_vld_reg        <= 1'b0;
            f_vld_reg        <= 1'b0;
            g_vld_reg        <= 1'b0;
            h_vld_reg        <= 1'b0;
            i_vld_reg        <= 1'b0;
            j_vld_reg        <= 1'b0;
            k_vld_reg        <= 1'b0;
            l_vld_reg        <= 1'b0;
            m_vld_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg        <= vertex_valid;
            b_vld_reg        <= a_vld_reg;
            c_vld_reg        <= b_vld_reg;
            d_vld_reg        <= c_vld_reg;
            e_vld_reg        <= t_vld;
            f_vld_reg        <= e_vld_reg;
            g_vld_reg        <= f_vld_reg;
            h_vld_reg        <= g_vld_reg;
            i_vld_reg        <= s_vld;
            j_vld_reg        <= fq_vld;
            k_vld_reg        <= j_vld_reg;
            l_vld_reg        <= k_vld_reg;
            m_vld_reg        <= l_vld_reg;
            result_valid_reg <= m_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_a_reg  <= ax_a_next;
            az_a_reg  <= az_a_next;
            dx_a_reg  <= dx_a_next;
            dz_a_reg  <= dz_a_next;
            cur_a_reg <= vertex.current_height;

            ax_b_reg  <= scale(ax_a_reg, scl_b_next);
            az_b_reg  <= scale(az_a_reg, scl_b_next);
            dx_b_reg  <= scale(dx_a_reg, scl_b_next);
            dz_b_reg  <= scale(dz_a_reg, scl_b_next);
            scl_b_reg <= scl_b_next;
            cur_b_reg <= cur_a_reg;

            axdx_c_reg <= ax_b_reg * dx_b_reg;
            azdz_c_reg <= az_b_reg * dz_b_reg;
            dxx_c_reg  <= dx_b_reg * dx_b_reg;
            dzz_c_reg  <= dz_b_reg * dz_b_reg;
            ax_c_reg   <= ax_b_reg;
            az_c_reg   <= az_b_reg;
            dx_c_reg   <= dx_b_reg;
            dz_c_reg   <= dz_b_reg;
            scl_c_reg  <= scl_b_reg;
            cur_c_reg  <= cur_b_reg;

            num_d_reg          <= num_d_next[TW-1:0];
            den_d_reg          <= den_d_next[TW-1:0];
            tflag_d_reg        <= tflag_d_next;
            tside_d_reg.ax     <= ax_c_reg;
            tside_d_reg.az     <= az_c_reg;
            tside_d_reg.dx     <= dx_c_reg;
            tside_d_reg.dz     <= dz_c_reg;
            tside_d_reg.scl    <= scl_c_reg;
            tside_d_reg.seg_ok <= seg_ok_d_next;
            tside_d_reg.cur    <= cur_c_reg;

            dxt_e_reg    <= dxt_e_next;
            dzt_e_reg    <= dzt_e_next;
            hdt_e_reg    <= hdt_e_next;
            ax_e_reg     <= t_side.ax;
            az_e_reg     <= t_side.az;
            cur_e_reg    <= t_side.cur;
            scl_e_reg    <= t_side.scl;
            seg_ok_e_reg <= t_side.seg_ok;

            magx_f_reg   <= magx_f_next;
            magz_f_reg   <= magz_f_next;
            target_f_reg <= target_f_next;
            cur_f_reg    <= cur_e_reg;
            scl_f_reg    <= scl_e_reg;
            seg_ok_f_reg <= seg_ok_e_reg;

            sqx_g_reg          <= magx_f_reg * magx_f_reg;
            sqz_g_reg          <= magz_f_reg * magz_f_reg;
            sside_g_reg.scl    <= scl_f_reg;
            sside_g_reg.seg_ok <= seg_ok_f_reg;
            sside_g_reg.cur    <= cur_f_reg;
            sside_g_reg.target <= target_f_reg;

            rad_h_reg   <= sqx_g_reg + sqz_g_reg;
            sside_h_reg <= sside_g_reg;

            fnum_i_reg         <= diff_i[FW-1:0];
            fflag_i_reg        <= fflag_i_next;
            fside_i_reg.in_fp  <= in_fp_i;
            fside_i_reg.band   <= band_i;
            fside_i_reg.cur    <= s_side.cur;
            fside_i_reg.target <= s_side.target;

            fsq_j_reg  <= f_q * f_q;
            kf_j_reg   <= kf_j_next;
            side_j_reg <= f_side;

            prod_k_reg <= fsq_j_reg * kf_j_reg;
            side_k_reg <= side_j_reg;

            blend_l_reg <= blend_l_next;
            delta_l_reg <= 35'(side_k_reg.target) - 35'(side_k_reg.cur);
            side_l_reg  <= side_k_reg;

            pr_m_reg   <= delta_l_reg * signed'({1'b0, blend_l_reg});
            side_m_reg <= side_l_reg;

            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && i_vld_reg) |=> (i_vld_reg && $stable(fnum_i_reg) && $stable(fflag_i_reg)))
        else $error("falloff setup stage changed while the pipeline was held");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        t_vld |-> (t_q <= ONE_Q16))
        else $error("projection ratio above one");

    a_f_exact_one: assert property (@(posedge clk) disable iff (!rst_n)
        (fq_vld && f_side.band) |-> (f_q <= ONE_Q16))
        else $error("falloff fraction above one inside the band");

    a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
        (l_vld_reg && !side_l_reg.band) |-> (blend_l_reg == ONE_Q16))
        else $error("blend weight not full outside the falloff band");
`endif

endmodule

// ===== dv/tb_terrain_ramp_vertex_blend.sv =====
`timescale 1ns / 100ps

module tb_terrain_ramp_vertex_blend;
    import tvb_pkg::*;

    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 6000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 55;

    // index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    logic                 clk;
    logic                 rst_n;
    logic                 vertex_valid;
    logic                 vertex_ready;
    vertex_t              vertex;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    logic [31:0] ramp_reg [8];
    vertex_t     pending_vertices[$];
    result_t     expected_heights[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          hold_cnt;
    bit          hold_req;
    bit          vertex_taken;
    int          quiet_cycles;

    terrain_ramp_vertex_blend uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned mag64(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint rnd_shift(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // blended height of one vertex against the current ramp registers
    function automatic result_t blend_height(vertex_t v);
        longint vx, vz, cur, sx, sz, sh, ex, ez, eh, hw, fw;
        longint ax, az, dx, dz, num, t, px, pz, target, blend, newh;
        longint unsigned m, den, seg, perp, f, sm, r, q;
        int s;
        result_t res;
        vx  = v.vertex_x;
        vz  = v.vertex_z;
        cur = v.current_height;
        sx  = $signed(ramp_reg[REG_START_X]);
        sz  = $signed(ramp_reg[REG_START_Z]);
        sh  = $signed(ramp_reg[REG_START_HEIGHT]);
        ex  = $signed(ramp_reg[REG_END_X]);
        ez  = $signed(ramp_reg[REG_END_Z]);
        eh  = $signed(ramp_reg[REG_END_HEIGHT]);
        hw  = longint'(ramp_reg[REG_HALF_WIDTH][30:0]);
        fw  = longint'(ramp_reg[REG_FALLOFF_WIDTH][30:0]);
        ax  = vx - sx;
        az  = vz - sz;
        dx  = ex - sx;
        dz  = ez - sz;
        newh = cur;
        res.touched = 1'b0;
        m = mag64(ax);
        if (mag64(az) > m) m = mag64(az);
        if (mag64(dx) > m) m = mag64(dx);
        if (mag64(dz) > m) m = mag64(dz);
        s = 0;
        while (s < 2 && ((m + (64'd1 << s) - 1) >> s) > (64'd1 << 30))
            s++;
        ax = ax >>> s;
        az = az >>> s;
        dx = dx >>> s;
        dz = dz >>> s;
        den = longint'(dx * dx) + longint'(dz * dz);
        seg = int_sqrt(den) << s;
        if (seg >= 655)
        begin
            num = ax * dx + az * dz;
            if (num <= 0)
                t = 0;
            else if (longint'(num) >= longint'(den))
                t = 65536;
            else
            begin
                r = num;
                q = 0;
                for (int i = 0; i < 16; i++)
                begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= den)
                    begin
                        r = r - den;
                        q = q | 1;
                    end
                end
                t = q;
            end
            px = rnd_shift(ax * 65536 - dx * t, 16);
            pz = rnd_shift(az * 65536 - dz * t, 16);
            perp = int_sqrt(longint'(px * px) + longint'(pz * pz)) << s;
            if (longint'(perp) <= hw + fw)
            begin
                target = sh + rnd_shift((eh - sh) * t, 16);
                blend  = 65536;
                if (longint'(perp) > hw && fw > 0)
                begin
                    f     = ((longint'(perp) - hw) <<< 16) / fw;
                    sm    = (f * f * (64'd196608 - 2 * f) + (64'd1 << 31)) >> 32;
                    blend = 65536 - longint'(sm);
                end
                newh = cur + rnd_shift((target - cur) * blend, 16);
                if (newh > 64'sd2147483647) newh = 64'sd2147483647;
                if (newh < -64'sd2147483648) newh = -64'sd2147483648;
                res.touched = 1'b1;
            end
        end
        res.new_height = newh[31:0];
        return res;
    endfunction

    // vertex driver
    always @(negedge clk)
    begin
        if (!rst_n)
            vertex_valid <= 1'b0;
        else if (vertex_valid && !vertex_taken)
            ;
        else if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            vertex       <= pending_vertices.pop_front();
            vertex_valid <= 1'b1;
        end
        else
            vertex_valid <= 1'b0;
        vertex_taken = 1'b0;
    end

    // result receiver, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on request, check on result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (vertex_valid && vertex_ready)
            begin
                expected_heights = {expected_heights, blend_height(vertex)};
                vertex_taken = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                if (expected_heights.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: new_height=%h touched=%b",
                                 result.new_height, result.touched);
                end
                else
                begin
                    result_t exp_res;
                    exp_res = expected_heights.pop_front();
                    if (result.new_height !== exp_res.new_height ||
                        result.touched !== exp_res.touched)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: new_height exp %h got %h, touched exp %b got %b",
                                     exp_res.new_height, result.new_height,
                                     exp_res.touched, result.touched);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((vertex_valid && vertex_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        // registers change only with nothing in flight
        while (pending_vertices.size() > 0 || vertex_valid || expected_heights.size() > 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_HALF_WIDTH || idx == REG_FALLOFF_WIDTH)
            ramp_reg[idx] = val & 32'h7FFF_FFFF;
        else if (idx <= REG_FALLOFF_WIDTH)
            ramp_reg[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ramp(input logic [31:0] sx, sz, sh, ex, ez, eh, hw, fw);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Z, sz);
        write_reg(REG_START_HEIGHT, sh);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Z, ez);
        write_reg(REG_END_HEIGHT, eh);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_FALLOFF_WIDTH, fw);
    endtask

    task automatic add_vertex(input logic [31:0] x, z, h);
        vertex_t v;
        v.vertex_x       = x;
        v.vertex_z       = z;
        v.current_height = h;
        pending_vertices = {pending_vertices, v};
    endtask

    task automatic drain_all();
        while (pending_vertices.size() > 0 || vertex_valid || expected_heights.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // vertex near the ramp: a point along the segment plus a random offset on each axis
    task automatic add_near_vertex();
        longint sx, sz, dx, dz, frac, reach, offx, offz;
        sx    = $signed(ramp_reg[REG_START_X]);
        sz    = $signed(ramp_reg[REG_START_Z]);
        dx    = $signed(ramp_reg[REG_END_X]) - sx;
        dz    = $signed(ramp_reg[REG_END_Z]) - sz;
        frac  = longint'($urandom_range(81920)) - 8192;
        reach = longint'(ramp_reg[REG_HALF_WIDTH][30:0]) +
                longint'(ramp_reg[REG_FALLOFF_WIDTH][30:0]);
        reach = reach + reach / 2 + 1;
        if (reach > 64'd2000000000) reach = 64'd2000000000;
        offx  = longint'($urandom_range(32'(2 * reach))) - reach;
        offz  = longint'($urandom_range(32'(2 * reach))) - reach;
        add_vertex(32'(sx + ((dx * frac) >>> 16) + offx),
                   32'(sz + ((dz * frac) >>> 16) + offz), $urandom);
    endtask

    task automatic set_idle(input idle_mode_e mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 82 : (mode == IDLE_BOTH) ? 16 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 82 : (mode == IDLE_BOTH) ? 16 : 0;
    endtask

    initial
    begin
        logic [31:0] w;
        rst_n        = 1'b0;
        vertex_valid = 1'b0;
        vertex       = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        hold_cnt     = 0;
        hold_req     = 1'b0;
        vertex_taken = 1'b0;
        quiet_cycles = 0;
        set_idle(IDLE_NONE);
        for (int i = 0; i < 8; i++)
            ramp_reg[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: zero-length segment leaves everything alone
        add_vertex(32'h0, 32'h0, 32'h1234_5678);
        add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        drain_all();

        // segment just under the minimum length, then one at exactly the minimum length
        set_ramp(32'h0, 32'h0, 32'h0, 32'd654, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0);
        add_vertex(32'd300, 32'h0, 32'h7FFF_FFFF);
        write_reg(REG_END_X, 32'd655);
        add_vertex(32'd300, 32'h0, 32'h7FFF_FFFF);
        drain_all();

        set_ramp(32'hFFF6_0000, 32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h0014_0000,
                 32'h0002_0000, 32'h0003_0000);
        add_vertex(32'hFFF6_0000, 32'h0, 32'h0);        // at start
        add_vertex(32'h000A_0000, 32'h0, 32'h0);        // at end
        add_vertex(32'hFFE0_0000, 32'h0001_0000, 32'h5); // before start, clamped
        add_vertex(32'h0020_0000, 32'hFFFF_0000, 32'h5); // past end, clamped
        add_vertex(32'h0, 32'h0001_8000, 32'h0);        // inside half width
        add_vertex(32'h0, 32'h0002_0000, 32'h0);        // on half width edge
        add_vertex(32'h0, 32'h0003_8000, 32'h0);        // in falloff band
        add_vertex(32'h0, 32'h0005_0000, 32'h0);        // on outer edge
        add_vertex(32'h0, 32'h0005_0001, 32'h0);        // just outside
        add_vertex(32'h0, 32'h7FFF_FFFF, 32'h0);
        add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        drain_all();

        // zero falloff and saturation of the blend
        set_ramp(32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0064_0000, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'h0);
        add_vertex(32'h0, 32'h0032_0000, 32'h8000_0000);
        add_vertex(32'h0012_0000, 32'h0064_0000, 32'h7FFF_FFFF);
        write_reg(REG_HALF_WIDTH, 32'h0001_0000);
        add_vertex(32'h0, 32'h0032_0000, 32'h0);
        add_vertex(32'h0002_0000, 32'h0032_0000, 32'h0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        add_vertex(32'h0, 32'h0032_0000, 32'h0);
        drain_all();

        // full-scale coordinates: the prescale shift comes into play
        set_ramp(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_vertex(32'h0, 32'h0, 32'h0);
        add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain_all();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_idle(idle_mode_e'(p % 4));
            if (p == RAND_PHASES - 1)
                set_ramp(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
            else
            begin
                w = (p % 2) ? 32'h00FF_FFFF : 32'h3FFF_FFFF;
                set_ramp($urandom & w, $urandom & w, $urandom, $urandom & w, $urandom & w,
                         $urandom, $urandom & (w >> 3), $urandom & (w >> 3));
            end
            if (p == 4)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 80)
                    add_near_vertex();
                else
                    add_vertex($urandom, $urandom, $urandom);
            end
            drain_all();
        end

        if (mismatches == 0 && expected_heights.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tvb_pkg.sv
rtl/tvb_div.sv
rtl/tvb_sqrt.sv
rtl/terrain_ramp_vertex_blend.sv
dv/tb_terrain_ramp_vertex_blend.sv
